@@ src/pidl_pkg.sv @@
// shared types and constants of the positional insert/delete list
package pidl_pkg;

	localparam logic [4:0] DEF_CAP = 5'd5;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_DUMP   = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_DUMP_RD,
		ST_DUMP_PUT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic               ok;
		logic [4:0]         count;
		logic signed [31:0] element;
		logic               last;
	} res_t;

endpackage

@@ src/pidl_ifs.sv @@
// request, response and configuration channel interfaces
interface pidl_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [7:0]         position;
	logic signed [31:0] value;

	modport source (output valid, mode, position, value, input ready);
	modport sink (input valid, mode, position, value, output ready);
endinterface

interface pidl_rsp_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic [4:0]         count;
	logic signed [31:0] element;
	logic               last;

	modport source (output valid, ok, count, element, last, input ready);
	modport sink (input valid, ok, count, element, last, output ready);
endinterface

interface pidl_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] capacity_in_use;

	modport source (output valid, capacity_in_use, input ready);
	modport sink (input valid, capacity_in_use, output ready);
endinterface

@@ src/pidl_mem.sv @@
// list storage: one write port, one read port with registered read data
module pidl_mem #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic signed [31:0]         wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic signed [31:0]         rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/pidl_out.sv @@
// output register holding one result beat
module pidl_out
	import pidl_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  res_t           res,
	output logic           can_push,
	pidl_rsp_if.source     rsp
);

	logic valid_q;
	res_t res_q;

	assign can_push = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_push) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push) begin
			res_q <= res;
		end
	end

	assign rsp.valid   = valid_q;
	assign rsp.ok      = res_q.ok;
	assign rsp.count   = res_q.count;
	assign rsp.element = res_q.element;
	assign rsp.last    = res_q.last;

endmodule

@@ src/positional_insert_delete_list.sv @@
// positional insert/delete list: sequencer around a one-port-each-way list memory
// one request at a time; insert reads and rewrites each entry shifted up, then writes the new value
// delete reads and rewrites each entry shifted down (none when the last entry goes)
// dump reads each entry and puts it out as one beat before reading the next; a held response stalls it
// refused ops, mode 3 and empty dump go straight to their result beat
// reset clears count to 0 and capacity to 5; list memory is not cleared and needs no pass
module positional_insert_delete_list
	import pidl_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	pidl_req_if.sink    req,
	pidl_rsp_if.source  rsp,
	pidl_cfg_if.sink    cfg
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > 8) ? CW : 8) + 1;

	state_t             state_q, state_d;
	logic [CW-1:0]      n_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      p_q;
	logic signed [31:0] val_q;
	logic               ok_q;
	logic [4:0]         cap_q;

	logic [XW-1:0]      n_x, pos_x, cap_x, eff_x;
	logic [AW-1:0]      ins_p0, del_p0;
	logic               ins_room, ins_shift, del_shift, del_done, dump_last;

	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic signed [31:0] mem_wdata, mem_rdata;

	logic               push, can_push;
	res_t               res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= DEF_CAP;
		end else if (cfg.valid) begin
			cap_q <= cfg.capacity_in_use;
		end
	end

	// capacity in effect and target positions
	always_comb begin
		n_x   = XW'(n_q);
		pos_x = XW'(req.position);
		cap_x = (cap_q == 5'd0) ? XW'(DEF_CAP) : XW'(cap_q);
		eff_x = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
		ins_room = n_x < eff_x;
		if (pos_x == XW'(0) || pos_x > n_x + XW'(1)) begin
			ins_p0 = n_q[AW-1:0];
		end else begin
			ins_p0 = AW'(pos_x - XW'(1));
		end
		if (pos_x == XW'(0) || pos_x > n_x) begin
			del_p0 = AW'(n_x - XW'(1));
		end else begin
			del_p0 = AW'(pos_x - XW'(1));
		end
		ins_shift = n_x > XW'(ins_p0);
		del_shift = XW'(del_p0) + XW'(1) < n_x;
		del_done  = XW'(idx_q) + XW'(2) == n_x;
		dump_last = XW'(idx_q) + XW'(1) == n_x;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.mode)
						MODE_INSERT: state_d = !ins_room ? ST_RESULT :
							(ins_shift ? ST_INS_RD : ST_INS_PUT);
						MODE_DELETE: state_d = (n_q == '0 || !del_shift) ?
							ST_RESULT : ST_DEL_RD;
						MODE_DUMP: state_d = (n_q == '0) ? ST_RESULT : ST_DUMP_RD;
						default: state_d = ST_RESULT;
					endcase
				end
			end
			ST_INS_RD: state_d = ST_INS_WR;
			ST_INS_WR: state_d = (AW'(idx_q - AW'(1)) == p_q) ? ST_INS_PUT : ST_INS_RD;
			ST_INS_PUT: state_d = ST_RESULT;
			ST_DEL_RD: state_d = ST_DEL_WR;
			ST_DEL_WR: state_d = del_done ? ST_RESULT : ST_DEL_RD;
			ST_DUMP_RD: state_d = ST_DUMP_PUT;
			ST_DUMP_PUT: begin
				if (can_push) begin
					state_d = dump_last ? ST_IDLE : ST_DUMP_RD;
				end
			end
			ST_RESULT: begin
				if (can_push) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		push      = 1'b0;
		res       = '{ok: ok_q, count: n_x[4:0], element: 32'sd0, last: 1'b1};
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_INS_RD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(idx_q - AW'(1));
			end
			ST_INS_WR: mem_we = 1'b1;
			ST_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = p_q;
				mem_wdata = val_q;
			end
			ST_DEL_RD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(idx_q + AW'(1));
			end
			ST_DEL_WR: mem_we = 1'b1;
			ST_DUMP_RD: mem_re = 1'b1;
			ST_DUMP_PUT: begin
				push = 1'b1;
				res  = '{ok: 1'b1, count: n_x[4:0], element: mem_rdata, last: dump_last};
			end
			ST_RESULT: push = 1'b1;
			default: req.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.mode == MODE_DELETE && n_q != '0 && !del_shift) begin
						n_q <= CW'(n_q - CW'(1));
					end
				end
				ST_INS_PUT: n_q <= CW'(n_q + CW'(1));
				ST_DEL_WR: begin
					if (del_done) begin
						n_q <= CW'(n_q - CW'(1));
					end
				end
				default: n_q <= n_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					val_q <= req.value;
					case (req.mode)
						MODE_INSERT: begin
							p_q   <= ins_p0;
							idx_q <= n_q[AW-1:0];
							ok_q  <= 1'b0;
						end
						MODE_DELETE: begin
							p_q   <= del_p0;
							idx_q <= del_p0;
							ok_q  <= n_q != '0;
						end
						MODE_DUMP: begin
							idx_q <= '0;
							ok_q  <= 1'b1;
						end
						default: ok_q <= 1'b0;
					endcase
				end
			end
			ST_INS_WR: idx_q <= AW'(idx_q - AW'(1));
			ST_INS_PUT: ok_q <= 1'b1;
			ST_DEL_WR: idx_q <= AW'(idx_q + AW'(1));
			ST_DUMP_PUT: begin
				if (can_push && !dump_last) begin
					idx_q <= AW'(idx_q + AW'(1));
				end
			end
			default: idx_q <= idx_q;
		endcase
	end

	pidl_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pidl_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (res),
		.can_push (can_push),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(n_q) <= XW'(DEPTH))
		else $error("entry count above depth");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && mem_waddr == mem_raddr))
		else $error("read and write of one entry in one cycle");

	a_dump_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP_RD || state_q == ST_DUMP_PUT) |=> $stable(n_q))
		else $error("count changed during dump");
`endif

endmodule

@@ bench/positional_insert_delete_list_tb.sv @@
// testbench for the positional insert/delete list: directed table, then random phases
module positional_insert_delete_list_tb
	import pidl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         LIST_DEPTH  = 16;
	localparam int         SETTLE      = 40;
	localparam int         CYCLE_LIMIT = 200000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  position;
		logic [31:0] value;
		logic        typed;
		logic        ok;
		logic [4:0]  count;
	} op_row_t;

	typedef struct packed {
		logic [4:0] capacity;
		logic [7:0] ops;
		logic [6:0] insert_pct;
	} phase_t;

	localparam int N_DIRECTED = 21;
	localparam op_row_t DIRECTED [N_DIRECTED] = '{
		'{MODE_DUMP,   8'd0,   32'h0000_0000, 1'b1, 1'b1, 5'd0},
		'{MODE_DELETE, 8'd1,   32'h0000_0000, 1'b1, 1'b0, 5'd0},
		'{MODE_UNUSED, 8'd0,   32'h0000_0000, 1'b1, 1'b0, 5'd0},
		'{MODE_INSERT, 8'd0,   32'h7FFF_FFFF, 1'b1, 1'b1, 5'd1},
		'{MODE_INSERT, 8'd1,   32'h8000_0000, 1'b1, 1'b1, 5'd2},
		'{MODE_INSERT, 8'd255, 32'h0000_0000, 1'b1, 1'b1, 5'd3},
		'{MODE_INSERT, 8'd2,   32'hFFFF_FFFF, 1'b1, 1'b1, 5'd4},
		'{MODE_INSERT, 8'd5,   32'h5555_5555, 1'b1, 1'b1, 5'd5},
		'{MODE_INSERT, 8'd1,   32'hAAAA_AAAA, 1'b1, 1'b0, 5'd5},
		'{MODE_DUMP,   8'd0,   32'h0000_0000, 1'b0, 1'b0, 5'd0},
		'{MODE_DELETE, 8'd1,   32'h0000_0000, 1'b1, 1'b1, 5'd4},
		'{MODE_DELETE, 8'd0,   32'h0000_0000, 1'b1, 1'b1, 5'd3},
		'{MODE_DELETE, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd2},
		'{MODE_DUMP,   8'd7,   32'h0000_0000, 1'b0, 1'b0, 5'd0},
		'{MODE_DELETE, 8'd2,   32'h0000_0000, 1'b1, 1'b1, 5'd1},
		'{MODE_UNUSED, 8'd200, 32'h0000_1234, 1'b1, 1'b0, 5'd1},
		'{MODE_INSERT, 8'd1,   32'h1234_5678, 1'b1, 1'b1, 5'd2},
		'{MODE_DUMP,   8'd0,   32'h0000_0000, 1'b0, 1'b0, 5'd0},
		'{MODE_DELETE, 8'd0,   32'h0000_0000, 1'b1, 1'b1, 5'd1},
		'{MODE_DELETE, 8'd1,   32'h0000_0000, 1'b1, 1'b1, 5'd0},
		'{MODE_DUMP,   8'd0,   32'h0000_0000, 1'b1, 1'b1, 5'd0}
	};

	// capacity, ops, insert share; the last phase gets a random capacity and no idling
	localparam int N_PHASES = 7;
	localparam phase_t PHASES [N_PHASES] = '{
		'{5'd16, 8'd24, 7'd85},
		'{5'd31, 8'd12, 7'd50},
		'{5'd0,  8'd15, 7'd45},
		'{5'd1,  8'd15, 7'd25},
		'{5'd16, 8'd15, 7'd60},
		'{5'd3,  8'd15, 7'd45},
		'{5'd0,  8'd17, 7'd50}
	};

	logic clk = 1'b0;
	logic arst_n;

	pidl_req_if req_ch ();
	pidl_rsp_if rsp_ch ();
	pidl_cfg_if cfg_ch ();

	positional_insert_delete_list #(.DEPTH(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	logic signed [31:0] list_words [LIST_DEPTH];
	int                 word_count;
	logic [4:0]         capacity_reg;
	res_t               expected_beats [$];
	res_t               head_beat;
	int                 errors;
	int                 stall_left;
	bit                 quiet;
	int unsigned        cycle_count;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic res_t make_beat(logic ok, logic [4:0] count, logic signed [31:0] element,
		logic last);
		res_t b;
		b.ok      = ok;
		b.count   = count;
		b.element = element;
		b.last    = last;
		return b;
	endfunction

	function automatic int capacity_in_effect();
		int c;
		c = (capacity_reg == 5'd0) ? int'(DEF_CAP) : int'(capacity_reg);
		return (c > LIST_DEPTH) ? LIST_DEPTH : c;
	endfunction

	// list update and the beats it should produce
	function automatic void apply_list_op(logic [1:0] mode, logic [7:0] position,
		logic signed [31:0] value);
		int p;
		int i;
		logic ok;
		p  = int'(position);
		ok = 1'b0;
		case (mode)
			MODE_INSERT: begin
				if (word_count < capacity_in_effect() && word_count < LIST_DEPTH) begin
					if (p == 0 || p > word_count + 1)
						p = word_count + 1;
					for (i = word_count; i >= p; i--)
						list_words[i] = list_words[i - 1];
					list_words[p - 1] = value;
					word_count++;
					ok = 1'b1;
				end
				expected_beats.push_back(make_beat(ok, word_count[4:0], 32'sd0, 1'b1));
			end
			MODE_DELETE: begin
				if (word_count > 0) begin
					if (p == 0 || p > word_count)
						p = word_count;
					for (i = p - 1; i + 1 < word_count; i++)
						list_words[i] = list_words[i + 1];
					word_count--;
					ok = 1'b1;
				end
				expected_beats.push_back(make_beat(ok, word_count[4:0], 32'sd0, 1'b1));
			end
			MODE_DUMP: begin
				if (word_count == 0)
					expected_beats.push_back(make_beat(1'b1, 5'd0, 32'sd0, 1'b1));
				for (i = 0; i < word_count; i++)
					expected_beats.push_back(make_beat(1'b1, word_count[4:0], list_words[i],
						i == word_count - 1));
			end
			default: begin
				expected_beats.push_back(make_beat(1'b0, word_count[4:0], 32'sd0, 1'b1));
			end
		endcase
	endfunction

	task automatic issue_op(logic [1:0] mode, logic [7:0] position, logic signed [31:0] value);
		@(negedge clk);
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= mode;
		req_ch.position <= position;
		req_ch.value    <= value;
		do
			@(posedge clk);
		while (!req_ch.ready);
		apply_list_op(mode, position, value);
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(logic [4:0] cap);
		@(negedge clk);
		cfg_ch.valid           <= 1'b1;
		cfg_ch.capacity_in_use <= cap;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		capacity_reg = cap;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'($urandom_range(0, 255));
		if (r == 2)
			return 8'd255;
		return 8'($urandom_range(1, word_count + 1));
	endfunction

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'sh8000_0000;
		if (r == 1)
			return 32'sh7FFF_FFFF;
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_mode(int insert_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return MODE_UNUSED;
		if (r < 13)
			return MODE_DUMP;
		if (r < 13 + insert_pct)
			return MODE_INSERT;
		return MODE_DELETE;
	endfunction

	// response side: ready stalls in bursts
	always @(negedge clk) begin
		if (quiet) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= $urandom_range(0, 8);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				head_beat = expected_beats.pop_front();
				if (rsp_ch.ok !== head_beat.ok) begin
					$error("ok: expected %0d, got %0d", head_beat.ok, rsp_ch.ok);
					errors++;
				end
				if (rsp_ch.count !== head_beat.count) begin
					$error("count: expected %0d, got %0d", head_beat.count, rsp_ch.count);
					errors++;
				end
				if (rsp_ch.element !== head_beat.element) begin
					$error("element: expected %0d, got %0d", head_beat.element, rsp_ch.element);
					errors++;
				end
				if (rsp_ch.last !== head_beat.last) begin
					$error("last: expected %0d, got %0d", head_beat.last, rsp_ch.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [4:0] cap;
		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.mode            = MODE_INSERT;
		req_ch.position        = 8'd0;
		req_ch.value           = 32'sd0;
		rsp_ch.ready           = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.capacity_in_use = 5'd0;
		errors                 = 0;
		stall_left             = 0;
		quiet                  = 1'b0;
		cycle_count            = 0;
		word_count             = 0;
		capacity_reg           = DEF_CAP;
		for (int i = 0; i < LIST_DEPTH; i++)
			list_words[i] = 32'sd0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		for (int n = 0; n < N_DIRECTED; n++) begin
			issue_op(DIRECTED[n].mode, DIRECTED[n].position, DIRECTED[n].value);
			if (DIRECTED[n].typed) begin
				void'(expected_beats.pop_back());
				expected_beats.push_back(make_beat(DIRECTED[n].ok, DIRECTED[n].count, 32'sd0,
					1'b1));
			end
			sender_gap();
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			cap = PHASES[ph].capacity;
			if (ph == N_PHASES - 1) begin
				cap   = 5'($urandom_range(0, 31));
				quiet = 1'b1;
			end
			write_capacity(cap);
			for (int n = 0; n < int'(PHASES[ph].ops); n++) begin
				issue_op(pick_mode(int'(PHASES[ph].insert_pct)), pick_position(), pick_value());
				if (!quiet && $urandom_range(0, 24) == 0)
					wait_drained();
				sender_gap();
			end
		end

		wait_drained();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
